// ===== rtl/core/jsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types, character codes and helpers for the string decoder.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_END    = 3'd1,
    EV_NOTSTR = 3'd2,
    EV_BADHEX = 3'd3,
    EV_UNTERM = 3'd4
  } ev_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;

  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  localparam int unsigned QUEUE_DEPTH = 2;

  // One decoded input: up to three results, either data bytes or one event.
  typedef struct packed {
    logic [1:0]      cnt;
    logic            has;
    ev_t             ev;
    logic [2:0][7:0] bytes;
  } jsu_entry_t;

  typedef struct packed {
    logic       valid;
    jsu_entry_t entry;
  } jsu_head_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t r;
    r.is_hex = 1'b1;
    r.value  = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r.value = c[3:0] + 4'd9;
    end else begin
      r.is_hex = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/jsu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape front end
// Tracks the string state per source byte and classifies each byte into a
// queue entry holding its results.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               q_full,
  output logic               q_push,
  output jsu_pkg::jsu_entry_t q_entry
);
  import jsu_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_count_r, hex_count_nxt;
  logic [15:0] code_point_r, code_point_nxt;
  logic        accept;
  hex_digit_t  hd;
  logic [15:0] cp;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign hd       = hex_decode(in_byte);
  assign cp       = {code_point_r[11:0], hd.value};

  always_comb begin
    mode_nxt       = mode_r;
    hex_count_nxt  = hex_count_r;
    code_point_nxt = code_point_r;
    case (mode_r)
      MODE_IDLE: begin
        if (in_byte == CH_QUOTE) mode_nxt = MODE_STR;
      end
      MODE_STR: begin
        if (in_byte == CH_QUOTE || in_byte == CH_NUL) begin
          mode_nxt = MODE_IDLE;
        end else if (in_byte == CH_BSLASH) begin
          mode_nxt = MODE_ESC;
        end
      end
      MODE_ESC: begin
        if (in_byte == CH_NUL) begin
          mode_nxt = MODE_IDLE;
        end else if (in_byte == CH_U) begin
          mode_nxt       = MODE_HEX;
          hex_count_nxt  = 2'd0;
          code_point_nxt = 16'd0;
        end else begin
          mode_nxt = MODE_STR;
        end
      end
      MODE_HEX: begin
        if (in_byte == CH_NUL || !hd.is_hex) begin
          mode_nxt       = MODE_IDLE;
          hex_count_nxt  = 2'd0;
          code_point_nxt = 16'd0;
        end else if (hex_count_r != 2'd3) begin
          hex_count_nxt  = hex_count_r + 2'd1;
          code_point_nxt = cp;
        end else begin
          mode_nxt       = MODE_STR;
          hex_count_nxt  = 2'd0;
          code_point_nxt = 16'd0;
        end
      end
      default: mode_nxt = MODE_IDLE;
    endcase
  end

  always_comb begin
    q_entry = '0;
    q_entry.ev = EV_NONE;
    case (mode_r)
      MODE_IDLE: begin
        if (in_byte != CH_QUOTE) begin
          q_entry.cnt = 2'd1;
          q_entry.ev  = EV_NOTSTR;
        end
      end
      MODE_STR: begin
        if (in_byte == CH_QUOTE) begin
          q_entry.cnt = 2'd1;
          q_entry.ev  = EV_END;
        end else if (in_byte == CH_NUL) begin
          q_entry.cnt = 2'd1;
          q_entry.ev  = EV_UNTERM;
        end else if (in_byte != CH_BSLASH) begin
          q_entry.cnt      = 2'd1;
          q_entry.has      = 1'b1;
          q_entry.bytes[0] = in_byte;
        end
      end
      MODE_ESC: begin
        q_entry.cnt = 2'd1;
        q_entry.has = 1'b1;
        case (in_byte)
          CH_NUL: begin
            q_entry.has = 1'b0;
            q_entry.ev  = EV_UNTERM;
          end
          CH_N:      q_entry.bytes[0] = CTL_LF;
          CH_R:      q_entry.bytes[0] = CTL_CR;
          CH_T:      q_entry.bytes[0] = CTL_HT;
          CH_B:      q_entry.bytes[0] = CTL_BS;
          CH_F:      q_entry.bytes[0] = CTL_FF;
          CH_QUOTE,
          CH_BSLASH,
          CH_SLASH:  q_entry.bytes[0] = in_byte;
          default: begin
            q_entry.cnt = 2'd0;
            q_entry.has = 1'b0;
          end
        endcase
      end
      MODE_HEX: begin
        if (in_byte == CH_NUL) begin
          q_entry.cnt = 2'd1;
          q_entry.ev  = EV_UNTERM;
        end else if (!hd.is_hex) begin
          q_entry.cnt = 2'd1;
          q_entry.ev  = EV_BADHEX;
        end else if (hex_count_r == 2'd3) begin
          q_entry.has = 1'b1;
          if (cp[15:7] == 9'd0) begin
            q_entry.cnt      = 2'd1;
            q_entry.bytes[0] = {1'b0, cp[6:0]};
          end else if (cp[15:11] == 5'd0) begin
            q_entry.cnt      = 2'd2;
            q_entry.bytes[0] = UTF8_LEAD2 | {3'd0, cp[10:6]};
            q_entry.bytes[1] = UTF8_CONT | {2'd0, cp[5:0]};
          end else begin
            q_entry.cnt      = 2'd3;
            q_entry.bytes[0] = UTF8_LEAD3 | {4'd0, cp[15:12]};
            q_entry.bytes[1] = UTF8_CONT | {2'd0, cp[11:6]};
            q_entry.bytes[2] = UTF8_CONT | {2'd0, cp[5:0]};
          end
        end
      end
      default: q_entry = '0;
    endcase
  end

  assign q_push = accept && (q_entry.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      hex_count_r  <= 2'd0;
      code_point_r <= 16'd0;
    end else if (accept) begin
      mode_r       <= mode_nxt;
      hex_count_r  <= hex_count_nxt;
      code_point_r <= code_point_nxt;
    end
  end

endmodule

// ===== rtl/core/jsu_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape queue
// Two-entry queue of decoded items between the front and back ends.
// ----------------------------------------------------------------------------
module jsu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jsu_pkg::jsu_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output jsu_pkg::jsu_head_t  head
);
  import jsu_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  jsu_entry_t          slots_r [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     cnt_r, cnt_nxt;
  logic                do_pop;

  assign full       = (cnt_r == CntW'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.entry = slots_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/jsu_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape back end
// Walks the results of the queue head into a registered output stage.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic               clk,
  input  logic               rst_n,
  input  jsu_pkg::jsu_head_t head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_has_data,
  output logic [2:0]         out_event_res,
  output logic               out_last
);
  import jsu_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;
  logic       has_r;
  ev_t        ev_r;
  logic       last_r;
  logic [1:0] idx_r, idx_nxt;
  logic       load;
  logic       is_last;

  assign load    = !valid_r || !out_stall;
  assign is_last = (idx_r == head.entry.cnt - 2'd1);
  assign pop     = load && head.valid && is_last;
  assign idx_nxt = pop ? 2'd0 : idx_r + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else if (load) begin
      valid_r <= head.valid;
      if (head.valid) idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && head.valid) begin
      byte_r <= head.entry.bytes[idx_r];
      has_r  <= head.entry.has;
      ev_r   <= head.entry.ev;
      last_r <= is_last;
    end
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_has_data  = has_r;
  assign out_event_res = ev_r;
  assign out_last      = last_r;

endmodule

// ===== rtl/core/json_string_unescape_utf8_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8, top level
// Decodes a JSON quoted string one source byte per transaction. Each byte
// yields zero to three results: a decoded data byte, or one event (string
// end, not a string, bad hex digit, unterminated). A source byte is taken
// every cycle as long as each byte yields at most one result and the
// output does not stall. A \u escape that becomes two or three UTF-8
// bytes holds the single output register while those bytes go out one at
// a time. The two-entry queue between the parser and the output sequencer
// takes the next byte's transaction. If bytes that yield results follow
// without a gap, the input still stalls after a two-byte or three-byte
// result. Each result passes through a queue slot and then the output
// register. out_last marks the final result of a byte.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_data,
  output logic [2:0] out_event_res,
  output logic       out_last
);
  import jsu_pkg::*;

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  jsu_entry_t q_entry;
  jsu_head_t  q_head;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  jsu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  jsu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_has_data  (out_has_data),
    .out_event_res (out_event_res),
    .out_last      (out_last)
  );

endmodule

// ===== rtl/core/jsu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape checker
// Port-level checks on the result channel of the decoder.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_has_data,
  input logic [2:0] out_event_res,
  input logic       out_last
);
  import jsu_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_data_no_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_data |-> out_event_res == EV_NONE)
    else $error("data result carries an event");

  a_event_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_byte == 8'd0 && out_event_res != EV_NONE)
    else $error("event result malformed");

  a_event_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != EV_NONE |-> out_last)
    else $error("event result not last");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind json_string_unescape_utf8_top jsu_checker u_jsu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_byte      (out_byte),
  .out_has_data  (out_has_data),
  .out_event_res (out_event_res),
  .out_last      (out_last)
);

// ===== verif/tb_json_string_unescape_utf8_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8, testbench
// Feeds quoted-string source bytes through the valid/stall input channel and
// checks every result transaction against a decoder model kept in step with
// each accepted byte. A short table of directed bytes covers idle rejects,
// escapes, broken hex runs and unterminated strings; random well-formed
// strings with \u escapes of every UTF-8 length follow, mixed with broken
// strings and junk bytes. Both sides idle at random, and one long output
// stall fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8_top;
  import jsu_pkg::*;

  localparam int N_DIR          = 30;
  localparam int RANDOM_ITEMS   = 400;
  localparam int SQUEEZE_CYCLES = 200;
  localparam int CYCLE_LIMIT    = 500000;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    ev_t        ev;
    logic       is_last;
  } dec_res_t;

  typedef struct packed {
    logic     typed;
    dec_res_t want;
  } row_note_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    dec_res_t   want;
  } dir_row_t;

  localparam dec_res_t ANY = '0;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_data;
  logic [2:0] out_event_res;
  logic       out_last;

  json_string_unescape_utf8_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_has_data (out_has_data),
    .out_event_res(out_event_res),
    .out_last     (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder model state
  mode_t       dec_mode;
  logic [1:0]  dec_hex_cnt;
  logic [15:0] dec_cp;
  dec_res_t    step_res [3];

  dec_res_t    awaited_q [$];
  row_note_t   typed_rows_q [$];
  int          err_count = 0;
  int          bytes_sent = 0;
  int          strings_sent = 0;
  int          tx_style = 0;
  logic        squeeze = 1'b0;
  logic        squeezed = 1'b0;
  int unsigned cycle_count = 0;

  logic [7:0]  esc_letters [8] = '{CH_N, CH_R, CH_T, CH_B, CH_F, CH_QUOTE, CH_BSLASH,
                                    CH_SLASH};
  logic [15:0] cp_edges [6] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
                                16'hFFFF};

  dir_row_t dir_rows [N_DIR] = '{
    '{CH_NUL,    1'b1, '{8'h00, 1'b0, EV_NOTSTR, 1'b1}},
    '{8'hFF,     1'b1, '{8'h00, 1'b0, EV_NOTSTR, 1'b1}},
    '{CH_QUOTE,  1'b0, ANY},
    '{8'hFF,     1'b1, '{8'hFF, 1'b1, EV_NONE, 1'b1}},
    '{8'h01,     1'b1, '{8'h01, 1'b1, EV_NONE, 1'b1}},
    '{CH_BSLASH, 1'b0, ANY},
    '{CH_N,      1'b0, ANY},
    '{CH_BSLASH, 1'b0, ANY},
    '{8'h71,     1'b0, ANY},
    '{CH_BSLASH, 1'b0, ANY},
    '{CH_U,      1'b0, ANY},
    '{8'h46,     1'b0, ANY},
    '{8'h66,     1'b0, ANY},
    '{8'h46,     1'b0, ANY},
    '{8'h46,     1'b0, ANY},
    '{CH_BSLASH, 1'b0, ANY},
    '{CH_U,      1'b0, ANY},
    '{8'h67,     1'b1, '{8'h00, 1'b0, EV_BADHEX, 1'b1}},
    '{CH_QUOTE,  1'b0, ANY},
    '{CH_BSLASH, 1'b0, ANY},
    '{CH_NUL,    1'b1, '{8'h00, 1'b0, EV_UNTERM, 1'b1}},
    '{CH_QUOTE,  1'b0, ANY},
    '{CH_BSLASH, 1'b0, ANY},
    '{CH_U,      1'b0, ANY},
    '{8'h30,     1'b0, ANY},
    '{CH_NUL,    1'b1, '{8'h00, 1'b0, EV_UNTERM, 1'b1}},
    '{CH_QUOTE,  1'b0, ANY},
    '{CH_NUL,    1'b1, '{8'h00, 1'b0, EV_UNTERM, 1'b1}},
    '{CH_QUOTE,  1'b0, ANY},
    '{CH_QUOTE,  1'b1, '{8'h00, 1'b0, EV_END, 1'b1}}
  };

  function automatic void clear_decoder();
    dec_mode    = MODE_IDLE;
    dec_hex_cnt = 2'd0;
    dec_cp      = 16'h0000;
  endfunction

  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'd16;
  endfunction

  function automatic void emit(inout int n, input logic [7:0] data, input logic has,
                               input ev_t ev);
    step_res[n] = '{data, has, ev, 1'b0};
    n++;
  endfunction

  // advance the model by one source byte; results land in step_res
  function automatic int decode_byte(input logic [7:0] c);
    int          n;
    logic [4:0]  d;
    logic [15:0] cp;
    n = 0;
    case (dec_mode)
      MODE_IDLE: begin
        if (c == CH_QUOTE) dec_mode = MODE_STR;
        else emit(n, 8'h00, 1'b0, EV_NOTSTR);
      end
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          emit(n, 8'h00, 1'b0, EV_END);
          clear_decoder();
        end else if (c == CH_NUL) begin
          emit(n, 8'h00, 1'b0, EV_UNTERM);
          clear_decoder();
        end else if (c == CH_BSLASH) begin
          dec_mode = MODE_ESC;
        end else begin
          emit(n, c, 1'b1, EV_NONE);
        end
      end
      MODE_ESC: begin
        dec_mode = MODE_STR;
        case (c)
          CH_NUL: begin
            emit(n, 8'h00, 1'b0, EV_UNTERM);
            clear_decoder();
          end
          CH_N: emit(n, CTL_LF, 1'b1, EV_NONE);
          CH_R: emit(n, CTL_CR, 1'b1, EV_NONE);
          CH_T: emit(n, CTL_HT, 1'b1, EV_NONE);
          CH_B: emit(n, CTL_BS, 1'b1, EV_NONE);
          CH_F: emit(n, CTL_FF, 1'b1, EV_NONE);
          CH_QUOTE, CH_BSLASH, CH_SLASH: emit(n, c, 1'b1, EV_NONE);
          CH_U: begin
            dec_mode    = MODE_HEX;
            dec_hex_cnt = 2'd0;
            dec_cp      = 16'h0000;
          end
          default: ;
        endcase
      end
      default: begin
        d = nibble_of(c);
        if (c == CH_NUL) begin
          emit(n, 8'h00, 1'b0, EV_UNTERM);
          clear_decoder();
        end else if (d[4]) begin
          emit(n, 8'h00, 1'b0, EV_BADHEX);
          clear_decoder();
        end else begin
          dec_cp = {dec_cp[11:0], d[3:0]};
          if (dec_hex_cnt != 2'd3) begin
            dec_hex_cnt = dec_hex_cnt + 2'd1;
          end else begin
            cp = dec_cp;
            if (cp <= 16'h007F) begin
              emit(n, cp[7:0], 1'b1, EV_NONE);
            end else if (cp <= 16'h07FF) begin
              emit(n, UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b1, EV_NONE);
              emit(n, UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, EV_NONE);
            end else begin
              emit(n, UTF8_LEAD3 | {4'b0000, cp[15:12]}, 1'b1, EV_NONE);
              emit(n, UTF8_CONT | {2'b00, cp[11:6]}, 1'b1, EV_NONE);
              emit(n, UTF8_CONT | {2'b00, cp[5:0]}, 1'b1, EV_NONE);
            end
            dec_mode    = MODE_STR;
            dec_hex_cnt = 2'd0;
            dec_cp      = 16'h0000;
          end
        end
      end
    endcase
    if (n > 0) step_res[n - 1].is_last = 1'b1;
    return n;
  endfunction

  task automatic cmp_field(input string what, input int unsigned exp_v,
                           input int unsigned act_v);
    if (exp_v != act_v) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, exp_v, act_v);
    end
  endtask

  task automatic check_result();
    dec_res_t want;
    if (awaited_q.size() == 0) begin
      err_count++;
      $display("%0t: unexpected result: expected none, actual byte=%0h has=%0b ev=%0d last=%0b",
               $time, out_byte, out_has_data, out_event_res, out_last);
    end else begin
      want = awaited_q.pop_front();
      cmp_field("out_byte", want.data, out_byte);
      cmp_field("out_has_data", want.has, out_has_data);
      cmp_field("out_event_res", want.ev, out_event_res);
      cmp_field("out_last", want.is_last, out_last);
    end
  endtask

  task automatic take_input(input logic [7:0] c);
    row_note_t note;
    int        n;
    note = '0;
    if (typed_rows_q.size() != 0) note = typed_rows_q.pop_front();
    n = decode_byte(c);
    if (note.typed) begin
      awaited_q.push_back(note.want);
    end else begin
      for (int i = 0; i < n; i++) awaited_q.push_back(step_res[i]);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_input(in_byte);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic int draw_wait(input int style);
    case (style)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 18)) : 0;
      default: return $urandom_range(0, 18);
    endcase
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41) + 8'(v) - 8'd10;
  endfunction

  task automatic send(input logic [7:0] b, input logic typed = 1'b0,
                      input dec_res_t want = '0);
    int gap;
    gap = squeeze ? 0 : draw_wait(tx_style);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_rows_q.push_back('{typed, want});
    in_valid <= 1'b1;
    in_byte  <= b;
    bytes_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_hex_digits(input int count, input logic [15:0] cp);
    for (int i = 0; i < count; i++) send(hex_char(cp[15 - 4 * i -: 4]));
  endtask

  task automatic send_unicode(input logic wide);
    logic [15:0] cp;
    int          cls;
    cls = wide ? 2 : $urandom_range(0, 4);
    case (cls)
      0: cp = 16'($urandom_range(0, 16'h007F));
      1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
      2: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
      3: cp = 16'($urandom_range(16'hD800, 16'hDFFF));
      default: cp = cp_edges[$urandom_range(0, 5)];
    endcase
    send(CH_BSLASH);
    send(CH_U);
    send_hex_digits(4, cp);
  endtask

  task automatic send_piece();
    logic [7:0] b;
    logic       known;
    int         pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BSLASH);
      send(b);
    end else if (pick < 7) begin
      send(CH_BSLASH);
      pick = $urandom_range(0, 8);
      if (pick < 8) begin
        send(esc_letters[pick]);
      end else begin
        do begin
          b = 8'($urandom_range(1, 255));
          known = (b == CH_U);
          foreach (esc_letters[j]) if (b == esc_letters[j]) known = 1'b1;
        end while (known);
        send(b);
      end
    end else begin
      send_unicode(1'b0);
    end
  endtask

  initial begin
    int         hold;
    int         rx_style;
    int         got;
    got      = 0;
    rx_style = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (squeeze && !squeezed) begin
        squeezed = 1'b1;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
      end
      if (got % 32 == 0) rx_style = $urandom_range(0, 2);
      hold = draw_wait(rx_style);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  initial begin
    int         ending;
    logic [7:0] b;
    clear_decoder();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_style = 0;
    foreach (dir_rows[i]) send(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    while (bytes_sent < N_DIR + RANDOM_ITEMS) begin
      strings_sent++;
      tx_style = $urandom_range(0, 2);
      if (strings_sent == 12) begin
        squeeze = 1'b1;
        send(CH_QUOTE);
        repeat (20) send_unicode(1'b1);
        send(CH_QUOTE);
        squeeze = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          send(CH_QUOTE);
          repeat ($urandom_range(0, 4)) send_piece();
          ending = $urandom_range(0, 3);
          if (ending != 0) send(CH_BSLASH);
          if (ending >= 2) begin
            send(CH_U);
            send_hex_digits($urandom_range(0, 3), 16'($urandom_range(0, 16'hFFFF)));
          end
          if (ending == 3) begin
            do b = 8'($urandom_range(1, 255)); while (nibble_of(b) != 5'd16);
            send(b);
          end else begin
            send(CH_NUL);
          end
        end
        2: begin
          repeat ($urandom_range(1, 3)) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
            send(b);
          end
        end
        default: begin
          send(CH_QUOTE);
          repeat ($urandom_range(0, 10)) send_piece();
          send(CH_QUOTE);
        end
      endcase
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
